// File: rtl/ust_pkg.sv
package ust_pkg;

	localparam int KEY_WIDTH_DEF = 32;
	localparam int CAPACITY_DEF  = 64;

	// fixed field widths of the request and response words
	localparam int KEY_BITS   = 32;
	localparam int COUNT_BITS = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2
	} req_type_t;

endpackage

// File: rtl/ust_if.sv
interface ust_req_if import ust_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          req_type;
	logic [KEY_BITS-1:0] key;

	modport source (output valid, output req_type, output key, input ready);
	modport sink (input valid, input req_type, input key, output ready);
endinterface

interface ust_rsp_if import ust_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic                  rejected;
	logic [COUNT_BITS-1:0] live_count;

	modport source (output valid, output found, output rejected, output live_count,
		input ready);
	modport sink (input valid, input found, input rejected, input live_count,
		output ready);
endinterface

// File: rtl/unordered_set_table_top.sv
// unordered set of keys held in a single memory with a live count
// request channel (req): req_type (insert, remove, lookup) and key; a word is
// taken when valid and ready are both high. ready is high only while the block
// is idle and its response register is empty or being emptied in that cycle.
// response channel (rsp): found, rejected and live_count, one word per request,
// held in an output register until the receiver takes it.
// scan: the live entries are read one per cycle through the registered read
// port of the key memory and compared with the key. a remove that hits then
// reads the last live entry in S_RDLAST and writes it over the hit slot in
// S_WRLAST. requests are handled one at a time: a new one is taken only when
// the block is back in idle, so the linear scan over the memory port sets the
// pace.
// reset: the live count clears to zero; the memory is not cleared, since only
// entries below the count are ever read.
// a stalled receiver holds the response register and blocks new requests.
module unordered_set_table_top import ust_pkg::*; #(
	parameter int KEY_WIDTH = KEY_WIDTH_DEF,
	parameter int CAPACITY  = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ust_req_if.sink   req,
	ust_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RDLAST,
		S_WRLAST
	} state_t;

	state_t               state_q, state_d;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [CW-1:0]        idx_q, idx_d;
	logic [CW-1:0]        idx_s1;
	logic                 pend_s1;
	logic [AW-1:0]        pos_q, pos_d;
	logic [1:0]           op_q;
	logic [KEY_WIDTH-1:0] key_q;

	logic                 out_vld_q;
	logic                 fnd_q;
	logic                 rej_q;
	logic [COUNT_BITS-1:0] live_q;

	logic                 we;
	logic [AW-1:0]        waddr;
	logic [KEY_WIDTH-1:0] wdata;
	logic [AW-1:0]        raddr;
	logic [KEY_WIDTH-1:0] rdata;

	logic                 in_fire;
	logic                 scan_rd;
	logic                 hit;
	logic                 miss;
	logic                 fin;
	logic                 fnd;
	logic                 rej;

	ust_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign req.ready = (state_q == S_IDLE) && (!out_vld_q || rsp.ready);
	assign in_fire   = req.valid && req.ready;

	assign rsp.valid      = out_vld_q;
	assign rsp.found      = fnd_q;
	assign rsp.rejected   = rej_q;
	assign rsp.live_count = live_q;

	assign scan_rd = (state_q == S_SCAN) && (idx_q < cnt_q);
	assign hit     = pend_s1 && (rdata == key_q);
	// an empty table misses at once
	assign miss    = (cnt_q == '0) ||
		(pend_s1 && (rdata != key_q) && (idx_s1 == CW'(cnt_q - 1'b1)));

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		pos_d   = pos_q;
		fin     = 1'b0;
		fnd     = 1'b0;
		rej     = 1'b0;
		we      = 1'b0;
		waddr   = AW'(cnt_q);
		wdata   = key_q;
		raddr   = AW'(idx_q);
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					idx_d   = '0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_rd) begin
					idx_d = CW'(idx_q + 1'b1);
				end
				if (hit) begin
					if (op_q == OP_REMOVE) begin
						pos_d   = AW'(idx_s1);
						state_d = S_RDLAST;
					end else begin
						fin     = 1'b1;
						fnd     = 1'b1;
						state_d = S_IDLE;
					end
				end else if (miss) begin
					if (op_q == OP_INSERT) begin
						if (cnt_q == CW'(CAPACITY)) begin
							rej = 1'b1;
						end else begin
							we    = 1'b1;
							cnt_d = CW'(cnt_q + 1'b1);
						end
					end
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RDLAST: begin
				raddr   = AW'(cnt_q - 1'b1);
				state_d = S_WRLAST;
			end
			S_WRLAST: begin
				// last live entry moves into the hit slot
				we      = 1'b1;
				waddr   = pos_q;
				wdata   = rdata;
				cnt_d   = CW'(cnt_q - 1'b1);
				fin     = 1'b1;
				fnd     = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			idx_q     <= '0;
			pend_s1   <= 1'b0;
			out_vld_q <= 1'b0;
			fnd_q     <= 1'b0;
			rej_q     <= 1'b0;
			live_q    <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			pend_s1 <= scan_rd;
			if (fin) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (fin) begin
				fnd_q  <= fnd;
				rej_q  <= rej;
				live_q <= COUNT_BITS'(cnt_d);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		pos_q  <= pos_d;
		if (in_fire) begin
			op_q  <= req.req_type;
			key_q <= KEY_WIDTH'(req.key);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("live count above capacity");

	a_wrlast_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRLAST) |-> (cnt_q != '0))
		else $error("swap with last on an empty table");

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !out_vld_q)
		else $error("response register overwritten before it was taken");

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(fnd_q && rej_q))
		else $error("response both found and rejected");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && !in_fire |=> $stable(cnt_q))
		else $error("live count changed while idle");

endmodule

// File: rtl/ust_ram.sv
module ust_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: tb/sv/testbench.sv
module testbench;
	import ust_pkg::*;

	localparam int KEY_WIDTH    = KEY_WIDTH_DEF;
	localparam int CAPACITY     = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1900;
	localparam int CYCLE_LIMIT  = 1_000_000;

	localparam logic [KEY_BITS-1:0] KEY_MASK  = {KEY_BITS{1'b1}} >> (KEY_BITS - KEY_WIDTH);
	// spare operation code, handled as a lookup
	localparam logic [1:0]          OP_UNUSED = 2'd3;

	typedef struct packed {
		logic                  found;
		logic                  rejected;
		logic [COUNT_BITS-1:0] live_count;
	} set_result_t;

	typedef struct {
		logic [1:0]          op;
		logic [KEY_BITS-1:0] key;
		bit                  typed;
		set_result_t         result;
	} probe_t;

	typedef enum {PH_GROW, PH_SHRINK, PH_MIXED} phase_kind_t;

	logic clk;
	logic arst_n;

	ust_req_if req_ch ();
	ust_rsp_if rsp_ch ();

	unordered_set_table_top #(
		.KEY_WIDTH(KEY_WIDTH),
		.CAPACITY (CAPACITY)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// shadow copy of the set
	logic [KEY_BITS-1:0] held_keys [CAPACITY];
	int unsigned         held_count;

	set_result_t pending_results [$];
	int          errors;
	int          cycle_count;
	bit          quiet;

	// directed words; the expected result is written out where it is obvious
	probe_t probes [20] = '{
		'{OP_LOOKUP, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd0}},
		'{OP_REMOVE, 32'h0000_0005, 1'b1, '{1'b0, 1'b0, 7'd0}},
		'{OP_INSERT, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd1}},
		'{OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd2}},
		'{OP_INSERT, 32'h0000_0000, 1'b1, '{1'b1, 1'b0, 7'd2}},
		'{OP_INSERT, 32'h8000_0000, 1'b1, '{1'b0, 1'b0, 7'd3}},
		'{OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd4}},
		'{OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd4}},
		'{OP_UNUSED, 32'h7FFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd4}},
		'{OP_UNUSED, 32'h0000_1234, 1'b1, '{1'b0, 1'b0, 7'd4}},
		'{OP_REMOVE, 32'h0000_0000, 1'b1, '{1'b1, 1'b0, 7'd3}},
		'{OP_LOOKUP, 32'h7FFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd3}},
		'{OP_REMOVE, 32'h7FFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd2}},
		'{OP_REMOVE, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd1}},
		'{OP_REMOVE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd1}},
		'{OP_LOOKUP, 32'h8000_0000, 1'b1, '{1'b1, 1'b0, 7'd1}},
		'{OP_REMOVE, 32'h8000_0000, 1'b1, '{1'b1, 1'b0, 7'd0}},
		'{OP_LOOKUP, 32'h8000_0000, 1'b1, '{1'b0, 1'b0, 7'd0}},
		'{OP_INSERT, 32'hAAAA_AAAA, 1'b0, '{1'b0, 1'b0, 7'd0}},
		'{OP_INSERT, 32'h5555_5555, 1'b0, '{1'b0, 1'b0, 7'd0}}
	};

	function automatic set_result_t apply_request(logic [1:0] op, logic [KEY_BITS-1:0] key_in);
		set_result_t         res;
		logic [KEY_BITS-1:0] k;
		int                  hit;
		k   = key_in & KEY_MASK;
		hit = -1;
		for (int i = 0; i < held_count; i++)
			if (hit < 0 && held_keys[i] == k) hit = i;
		res.found    = (hit >= 0);
		res.rejected = 1'b0;
		case (op)
			OP_INSERT: begin
				if (hit < 0) begin
					if (held_count >= CAPACITY) begin
						res.rejected = 1'b1;
					end else begin
						held_keys[held_count] = k;
						held_count++;
					end
				end
			end
			OP_REMOVE: begin
				// last live entry moves into the hole
				if (hit >= 0) begin
					held_keys[hit] = held_keys[held_count - 1];
					held_count--;
				end
			end
			default: ;
		endcase
		res.live_count = held_count[COUNT_BITS-1:0];
		return res;
	endfunction

	function automatic logic [KEY_BITS-1:0] choose_key(int held_pct);
		int r;
		if (held_count > 0 && $urandom_range(99) < held_pct)
			return held_keys[$urandom_range(held_count - 1)];
		r = $urandom_range(9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		// small keys so that absent keys repeat
		if (r < 4) return KEY_BITS'($urandom_range(15));
		return KEY_BITS'($urandom);
	endfunction

	task automatic send_request(input logic [1:0] op, input logic [KEY_BITS-1:0] k,
			input bit typed, input set_result_t typed_result);
		set_result_t predicted;
		int          gap;
		if (!quiet && $urandom_range(99) < 12) begin
			gap = $urandom_range(1, 40);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= op;
		req_ch.key      <= k;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = apply_request(op, k);
		pending_results.push_back(typed ? typed_result : predicted);
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// response side: random back-pressure and the field checks
	initial begin
		set_result_t want;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					$error("response word with no request outstanding");
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (rsp_ch.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp_ch.found);
						errors++;
					end
					if (rsp_ch.rejected !== want.rejected) begin
						$error("rejected: expected %0d, got %0d", want.rejected, rsp_ch.rejected);
						errors++;
					end
					if (rsp_ch.live_count !== want.live_count) begin
						$error("live_count: expected %0d, got %0d", want.live_count,
							rsp_ch.live_count);
						errors++;
					end
				end
			end
			rsp_ch.ready <= quiet || ($urandom_range(99) >= 10);
		end
	end

	initial begin
		phase_kind_t         kind;
		logic [1:0]          op;
		logic [KEY_BITS-1:0] k;
		int                  sent;
		int                  phase;
		int                  length;
		int                  r;
		errors          = 0;
		quiet           = 1'b0;
		held_count      = 0;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= OP_INSERT;
		req_ch.key      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i])
			send_request(probes[i].op, probes[i].key, probes[i].typed, probes[i].result);
		wait_for_results();

		// first phase grows the table with 120 words, mostly inserts
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			kind   = (phase == 0) ? PH_GROW : phase_kind_t'($urandom_range(2));
			length = (phase == 0) ? 120 : $urandom_range(40, 160);
			quiet  = (phase == 3);
			if (phase > 0 && $urandom_range(99) < 25) wait_for_results();
			for (int n = 0; n < length; n++) begin
				r = $urandom_range(99);
				case (kind)
					PH_GROW: begin
						if (r < 75) begin
							op = OP_INSERT; k = choose_key(0);
						end else if (r < 85) begin
							op = OP_INSERT; k = choose_key(100);
						end else if (r < 93) begin
							op = OP_LOOKUP; k = choose_key(50);
						end else begin
							op = OP_REMOVE; k = choose_key(70);
						end
					end
					PH_SHRINK: begin
						if (r < 70) begin
							op = OP_REMOVE; k = choose_key(100);
						end else if (r < 80) begin
							op = OP_REMOVE; k = choose_key(0);
						end else if (r < 95) begin
							op = OP_LOOKUP; k = choose_key(50);
						end else begin
							op = OP_INSERT; k = choose_key(30);
						end
					end
					default: begin
						op = 2'($urandom_range(3));
						k  = choose_key(50);
					end
				endcase
				send_request(op, k, 1'b0, '0);
				sent++;
			end
			phase++;
		end
		quiet = 1'b0;

		wait_for_results();
		repeat (CAPACITY + 8) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
